### rtl/ft12_pkg.sv
// Shared constants for the FT1.2 frame receiver.
`default_nettype none

package ft12_pkg;

  // Frame delimiters
  localparam logic [7:0] START_FIXED = 8'h10;
  localparam logic [7:0] START_VAR   = 8'h68;
  localparam logic [7:0] END_MARK    = 8'h16;

  // Link header bytes (C, A_lo, A_hi) counted in L
  localparam logic [7:0] HDR_LEN = 8'd3;

  // Receive phase codes
  localparam int PHASE_W = 4;
  localparam logic [PHASE_W-1:0] PH_HUNT   = 4'd0;
  localparam logic [PHASE_W-1:0] PH_CTRL   = 4'd1;
  localparam logic [PHASE_W-1:0] PH_ALO    = 4'd2;
  localparam logic [PHASE_W-1:0] PH_AHI    = 4'd3;
  localparam logic [PHASE_W-1:0] PH_ASDU   = 4'd4;
  localparam logic [PHASE_W-1:0] PH_CS     = 4'd5;
  localparam logic [PHASE_W-1:0] PH_END    = 4'd6;
  localparam logic [PHASE_W-1:0] PH_L1     = 4'd7;
  localparam logic [PHASE_W-1:0] PH_L2     = 4'd8;
  localparam logic [PHASE_W-1:0] PH_START2 = 4'd9;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict codes
  localparam logic [1:0] VERDICT_OK       = 2'd0;
  localparam logic [1:0] VERDICT_CHECKSUM = 2'd1;
  localparam logic [1:0] VERDICT_NOT_PRM  = 2'd2;
  localparam logic [1:0] VERDICT_ADDRESS  = 2'd3;

  // Control field bit positions
  localparam int CTRL_PRM = 6;
  localparam int CTRL_FCB = 5;
  localparam int CTRL_FCV = 4;

endpackage

`default_nettype wire

### rtl/ft12_if.sv
// Channel interfaces of the FT1.2 frame receiver: byte in, result out, config write.
`default_nettype none

interface ft12_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ft12_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [1:0]  verdict;
  logic        is_long_frame;
  logic [3:0]  function_code;
  logic        frame_count_bit;
  logic        frame_count_valid;
  logic [15:0] frame_address;
  logic [7:0]  asdu_type;
  logic [7:0]  asdu_length;

  modport source (output valid, output kind, output payload_byte, output verdict,
                  output is_long_frame, output function_code, output frame_count_bit,
                  output frame_count_valid, output frame_address, output asdu_type,
                  output asdu_length, input ready);
  modport sink   (input valid, input kind, input payload_byte, input verdict,
                  input is_long_frame, input function_code, input frame_count_bit,
                  input frame_count_valid, input frame_address, input asdu_type,
                  input asdu_length, output ready);
endinterface

interface ft12_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] station_address;

  modport source (output valid, output station_address, input ready);
  modport sink   (input valid, input station_address, output ready);
endinterface

`default_nettype wire

### rtl/ft12_frame_deframer_verifier.sv
// FT1.2 frame receiver: hunts frames, forwards ASDU bytes, checks sum, direction, address.
//
//   channel  | dir | payload                         | request taken when
//   ---------+-----+---------------------------------+--------------------
//   rx       | in  | rx_byte                         | rx.valid & rx.ready
//   result   | out | kind, payload_byte, verdict ... | result.valid & result.ready
//   cfg      | in  | station_address                 | cfg.valid (ready tied high)
//
// One byte per cycle: the frame state and the result are computed in one pass
// from the phase registers and the byte, and the result lands in an output register.
// rx.ready stays high while the output register is empty or being drained, so a
// stalled result stops the input only once the register is full.
// rst (synchronous) returns the hunt, clears all frame state and the station address.
`default_nettype none

module ft12_frame_deframer_verifier
  import ft12_pkg::*;
(
  input  wire               clk,
  input  wire               rst,
  ft12_byte_if.sink         rx,
  ft12_result_if.source     result,
  ft12_cfg_if.sink          cfg
);

  // Frame state
  logic [PHASE_W-1:0] phase, phase_next;
  logic [7:0]  declared_length, declared_length_next;
  logic [7:0]  byte_position, byte_position_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  control_byte, control_byte_next;
  logic [15:0] captured_address, captured_address_next;
  logic [7:0]  first_asdu_byte, first_asdu_byte_next;
  logic        frame_is_long, frame_is_long_next;
  logic [7:0]  received_sum, received_sum_next;
  logic [15:0] station_address;

  // Output register
  logic        out_valid;
  logic        out_kind;
  logic [7:0]  out_payload;
  logic [1:0]  out_verdict;
  logic        out_long;
  logic [3:0]  out_fc;
  logic        out_fcb;
  logic        out_fcv;
  logic [15:0] out_addr;
  logic [7:0]  out_type;
  logic [7:0]  out_len;

  logic        accept;
  logic        emit;
  logic        emit_kind;
  logic [1:0]  verdict_calc;
  logic [7:0]  b;
  logic [7:0]  asdu_len;
  logic [7:0]  pos_inc;

  assign b       = rx.rx_byte;
  assign rx.ready = !out_valid || result.ready;
  assign accept  = rx.valid && rx.ready;
  assign cfg.ready = 1'b1;
  assign asdu_len = declared_length - HDR_LEN;
  assign pos_inc  = byte_position + 8'd1;

  always_comb begin
    if (received_sum != running_sum) begin
      verdict_calc = VERDICT_CHECKSUM;
    end else if (!control_byte[CTRL_PRM]) begin
      verdict_calc = VERDICT_NOT_PRM;
    end else if (captured_address != station_address) begin
      verdict_calc = VERDICT_ADDRESS;
    end else begin
      verdict_calc = VERDICT_OK;
    end
  end

  always_comb begin
    logic restart;
    logic [7:0] hunt_byte;
    phase_next            = phase;
    declared_length_next  = declared_length;
    byte_position_next    = byte_position;
    running_sum_next      = running_sum;
    control_byte_next     = control_byte;
    captured_address_next = captured_address;
    first_asdu_byte_next  = first_asdu_byte;
    frame_is_long_next    = frame_is_long;
    received_sum_next     = received_sum;
    emit      = 1'b0;
    emit_kind = KIND_PAYLOAD;
    restart   = 1'b0;
    hunt_byte = b;

    unique case (phase)
      PH_L1: begin
        if (b < HDR_LEN) begin
          restart = 1'b1;
        end else begin
          declared_length_next = b;
          phase_next = PH_L2;
        end
      end
      PH_L2: begin
        if (b != declared_length) restart = 1'b1;
        else phase_next = PH_START2;
      end
      PH_START2: begin
        if (b != START_VAR) restart = 1'b1;
        else phase_next = PH_CTRL;
      end
      PH_CTRL: begin
        control_byte_next = b;
        running_sum_next  = b;
        phase_next = PH_ALO;
      end
      PH_ALO: begin
        captured_address_next = {8'd0, b};
        running_sum_next = running_sum + b;
        phase_next = PH_AHI;
      end
      PH_AHI: begin
        captured_address_next = {b, captured_address[7:0]};
        running_sum_next = running_sum + b;
        byte_position_next = 8'd0;
        if (frame_is_long && declared_length > HDR_LEN) phase_next = PH_ASDU;
        else phase_next = PH_CS;
      end
      PH_ASDU: begin
        if (byte_position == 8'd0) first_asdu_byte_next = b;
        running_sum_next   = running_sum + b;
        byte_position_next = pos_inc;
        if (pos_inc >= asdu_len) phase_next = PH_CS;
        emit      = 1'b1;
        emit_kind = KIND_PAYLOAD;
      end
      PH_CS: begin
        received_sum_next = b;
        phase_next = PH_END;
      end
      PH_END: begin
        restart = 1'b1;
        if (b == END_MARK) begin
          // verdict, then back to idle hunt
          emit      = 1'b1;
          emit_kind = KIND_VERDICT;
          hunt_byte = 8'd0;
        end
      end
      default: restart = 1'b1;
    endcase

    if (restart) begin
      declared_length_next  = 8'd0;
      byte_position_next    = 8'd0;
      running_sum_next      = 8'd0;
      control_byte_next     = 8'd0;
      captured_address_next = 16'd0;
      first_asdu_byte_next  = 8'd0;
      received_sum_next     = 8'd0;
      if (hunt_byte == START_FIXED) begin
        frame_is_long_next = 1'b0;
        phase_next = PH_CTRL;
      end else if (hunt_byte == START_VAR) begin
        frame_is_long_next = 1'b1;
        phase_next = PH_L1;
      end else begin
        frame_is_long_next = 1'b0;
        phase_next = PH_HUNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      declared_length  <= 8'd0;
      byte_position    <= 8'd0;
      running_sum      <= 8'd0;
      control_byte     <= 8'd0;
      captured_address <= 16'd0;
      first_asdu_byte  <= 8'd0;
      frame_is_long    <= 1'b0;
      received_sum     <= 8'd0;
      station_address  <= 16'd0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg.valid) station_address <= cfg.station_address;
      if (accept) begin
        phase            <= phase_next;
        declared_length  <= declared_length_next;
        byte_position    <= byte_position_next;
        running_sum      <= running_sum_next;
        control_byte     <= control_byte_next;
        captured_address <= captured_address_next;
        first_asdu_byte  <= first_asdu_byte_next;
        frame_is_long    <= frame_is_long_next;
        received_sum     <= received_sum_next;
      end
      if (accept && emit) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  // Result payload; only loaded when a new result is produced
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_kind <= emit_kind;
      if (emit_kind == KIND_PAYLOAD) begin
        out_payload <= b;
        out_verdict <= VERDICT_OK;
        out_long    <= 1'b0;
        out_fc      <= 4'd0;
        out_fcb     <= 1'b0;
        out_fcv     <= 1'b0;
        out_addr    <= 16'd0;
        out_type    <= 8'd0;
        out_len     <= 8'd0;
      end else begin
        out_payload <= 8'd0;
        out_verdict <= verdict_calc;
        out_long    <= frame_is_long;
        out_fc      <= control_byte[3:0];
        out_fcb     <= control_byte[CTRL_FCB];
        out_fcv     <= control_byte[CTRL_FCV];
        out_addr    <= captured_address;
        out_type    <= frame_is_long ? first_asdu_byte : 8'd0;
        out_len     <= frame_is_long ? asdu_len : 8'd0;
      end
    end
  end

  assign result.valid             = out_valid;
  assign result.kind              = out_kind;
  assign result.payload_byte      = out_payload;
  assign result.verdict           = out_verdict;
  assign result.is_long_frame     = out_long;
  assign result.function_code     = out_fc;
  assign result.frame_count_bit   = out_fcb;
  assign result.frame_count_valid = out_fcv;
  assign result.frame_address     = out_addr;
  assign result.asdu_type         = out_type;
  assign result.asdu_length       = out_len;

endmodule

`default_nettype wire

### tb/sv/tb_ft12_frame_deframer_verifier.sv
// Self-checking bench for the FT1.2 frame receiver: byte driver, result monitor, frame predictor.
module tb_ft12_frame_deframer_verifier;
  timeunit 1ns;
  timeprecision 1ps;
  import ft12_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_BYTES  = 240;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [1:0]  verdict;
    logic        is_long_frame;
    logic [3:0]  function_code;
    logic        frame_count_bit;
    logic        frame_count_valid;
    logic [15:0] frame_address;
    logic [7:0]  asdu_type;
    logic [7:0]  asdu_length;
  } ft12_result_t;

  typedef enum int {
    FLAW_NONE, FLAW_SUM, FLAW_END, FLAW_LEN2, FLAW_START2, FLAW_SHORT
  } frame_flaw_t;

  logic clk;
  logic rst;

  ft12_byte_if   rx_if();
  ft12_result_if res_if();
  ft12_cfg_if    cfg_if();

  ft12_frame_deframer_verifier DUT (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  // Byte stream waiting to go out, and deframed results still owed by the block
  logic [7:0]   line_bytes[$];
  ft12_result_t deframed_q[$];

  // Receiver state mirrored from the line
  logic [3:0]  rx_phase;
  logic [7:0]  l_decl;
  logic [7:0]  asdu_pos;
  logic [7:0]  sum_acc;
  logic [7:0]  ctrl_q;
  logic [15:0] addr_q;
  logic [7:0]  asdu_first;
  logic        long_q;
  logic [7:0]  cs_rx;
  logic [15:0] station_q;

  logic [15:0] station_sel;
  int          src_idle_pct;
  int          sink_stall_pct;
  int          bytes_built;
  int          bytes_sent;
  int          payload_seen;
  int          verdict_seen[4];
  int          errors;
  int          quiet_cycles;
  logic        rx_took;
  ft12_result_t got;
  ft12_result_t want;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void restart_hunt(input logic [7:0] b);
    l_decl     = '0;
    asdu_pos   = '0;
    sum_acc    = '0;
    ctrl_q     = '0;
    addr_q     = '0;
    asdu_first = '0;
    cs_rx      = '0;
    if (b == START_FIXED) begin
      long_q   = 1'b0;
      rx_phase = PH_CTRL;
    end else if (b == START_VAR) begin
      long_q   = 1'b1;
      rx_phase = PH_L1;
    end else begin
      long_q   = 1'b0;
      rx_phase = PH_HUNT;
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    ft12_result_t r;
    r = '0;
    case (rx_phase)
      PH_L1: begin
        if (b < HDR_LEN) restart_hunt(b);
        else begin
          l_decl   = b;
          rx_phase = PH_L2;
        end
      end
      PH_L2: begin
        if (b != l_decl) restart_hunt(b);
        else rx_phase = PH_START2;
      end
      PH_START2: begin
        if (b != START_VAR) restart_hunt(b);
        else rx_phase = PH_CTRL;
      end
      PH_CTRL: begin
        ctrl_q   = b;
        sum_acc  = b;
        rx_phase = PH_ALO;
      end
      PH_ALO: begin
        addr_q   = {8'h00, b};
        sum_acc  = sum_acc + b;
        rx_phase = PH_AHI;
      end
      PH_AHI: begin
        addr_q[15:8] = b;
        sum_acc      = sum_acc + b;
        asdu_pos     = '0;
        rx_phase     = (long_q && l_decl > HDR_LEN) ? PH_ASDU : PH_CS;
      end
      PH_ASDU: begin
        if (asdu_pos == 0) asdu_first = b;
        sum_acc  = sum_acc + b;
        asdu_pos = asdu_pos + 8'd1;
        if (asdu_pos >= l_decl - HDR_LEN) rx_phase = PH_CS;
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = b;
        deframed_q.push_back(r);
      end
      PH_CS: begin
        cs_rx    = b;
        rx_phase = PH_END;
      end
      PH_END: begin
        if (b != END_MARK) restart_hunt(b);
        else begin
          // checksum outranks direction, direction outranks address
          if (cs_rx != sum_acc) r.verdict = VERDICT_CHECKSUM;
          else if (!ctrl_q[CTRL_PRM]) r.verdict = VERDICT_NOT_PRM;
          else if (addr_q != station_q) r.verdict = VERDICT_ADDRESS;
          else r.verdict = VERDICT_OK;
          r.kind              = KIND_VERDICT;
          r.is_long_frame     = long_q;
          r.function_code     = ctrl_q[3:0];
          r.frame_count_bit   = ctrl_q[CTRL_FCB];
          r.frame_count_valid = ctrl_q[CTRL_FCV];
          r.frame_address     = addr_q;
          r.asdu_type         = long_q ? asdu_first : 8'h00;
          r.asdu_length       = long_q ? l_decl - HDR_LEN : 8'h00;
          deframed_q.push_back(r);
          restart_hunt(8'h00);
        end
      end
      default: restart_hunt(b);
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
    end
  endfunction

  function automatic void put(input logic [7:0] b);
    line_bytes.push_back(b);
    bytes_built++;
  endfunction

  task automatic queue_frame(input bit lng, input int n, input logic [7:0] c,
                             input logic [15:0] a, input frame_flaw_t flaw);
    logic [7:0] body[$];
    logic [7:0] cs;
    logic [7:0] l;
    logic [7:0] k;
    int         i;
    k = 8'($urandom_range(1, 255));
    body.push_back(c);
    body.push_back(a[7:0]);
    body.push_back(a[15:8]);
    for (i = 0; i < n; i++) body.push_back(8'($urandom));
    cs = '0;
    foreach (body[j]) cs = cs + body[j];
    if (lng) begin
      l = (flaw == FLAW_SHORT) ? 8'($urandom_range(2)) : 8'(n) + HDR_LEN;
      put(START_VAR);
      put(l);
      put(flaw == FLAW_LEN2 ? l ^ k : l);
      put(flaw == FLAW_START2 ? START_VAR ^ k : START_VAR);
    end else begin
      put(START_FIXED);
    end
    foreach (body[j]) put(body[j]);
    put(flaw == FLAW_SUM ? cs + k : cs);
    put(flaw == FLAW_END ? END_MARK ^ k : END_MARK);
  endtask

  // Mostly well-formed frames with random content, plus line noise and broken frames
  task automatic queue_traffic(input int budget);
    int          stop_at;
    int          r;
    int          n;
    bit          lng;
    logic [7:0]  c;
    logic [15:0] a;
    frame_flaw_t flaw;
    stop_at = bytes_built + budget;
    while (bytes_built < stop_at) begin
      r   = $urandom_range(99);
      lng = ($urandom_range(99) < 60);
      n   = ($urandom_range(99) < 2) ? $urandom_range(100, 252) : $urandom_range(0, 12);
      c   = 8'($urandom);
      if ($urandom_range(99) < 85) c[CTRL_PRM] = 1'b1;
      a   = ($urandom_range(99) < 75) ? station_sel : 16'($urandom);
      if (r < 10) begin
        repeat ($urandom_range(1, 4)) put(8'($urandom));
      end else if (r < 22) begin
        flaw = frame_flaw_t'($urandom_range(FLAW_END, FLAW_SHORT));
        queue_frame(flaw == FLAW_END ? lng : 1'b1, n, c, a, flaw);
      end else begin
        queue_frame(lng, n, c, a, ($urandom_range(99) < 10) ? FLAW_SUM : FLAW_NONE);
      end
    end
  endtask

  task automatic write_station(input logic [15:0] addr);
    @(negedge clk);
    cfg_if.valid           <= 1'b1;
    cfg_if.station_address <= addr;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Hold until the line is drained and every owed result has arrived
  task automatic wait_quiet();
    while (line_bytes.size() != 0 || rx_if.valid || deframed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Byte driver
  always @(negedge clk) begin
    if (rst) begin
      rx_if.valid <= 1'b0;
    end else if (!rx_if.valid || rx_took) begin
      if (line_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= line_bytes.pop_front();
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Result monitor, predictor update and watchdog
  always @(posedge clk) begin
    if (rst) begin
      rx_took      <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      rx_took <= rx_if.valid && rx_if.ready;
      // check before predicting so a spurious result cannot consume a fresh expectation
      if (res_if.valid && res_if.ready) begin
        got.kind              = res_if.kind;
        got.payload_byte      = res_if.payload_byte;
        got.verdict           = res_if.verdict;
        got.is_long_frame     = res_if.is_long_frame;
        got.function_code     = res_if.function_code;
        got.frame_count_bit   = res_if.frame_count_bit;
        got.frame_count_valid = res_if.frame_count_valid;
        got.frame_address     = res_if.frame_address;
        got.asdu_type         = res_if.asdu_type;
        got.asdu_length       = res_if.asdu_length;
        if (deframed_q.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, actual kind %0d payload 0x%0h",
                   $time, got.kind, got.payload_byte);
          $display("%0t: unexpected result verdict %0d", $time, got.verdict);
        end else begin
          want = deframed_q.pop_front();
          check_field("kind", 16'(want.kind), 16'(got.kind));
          check_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
          check_field("verdict", 16'(want.verdict), 16'(got.verdict));
          check_field("is_long_frame", 16'(want.is_long_frame), 16'(got.is_long_frame));
          check_field("function_code", 16'(want.function_code), 16'(got.function_code));
          check_field("frame_count_bit", 16'(want.frame_count_bit),
                      16'(got.frame_count_bit));
          check_field("frame_count_valid", 16'(want.frame_count_valid),
                      16'(got.frame_count_valid));
          check_field("frame_address", want.frame_address, got.frame_address);
          check_field("asdu_type", 16'(want.asdu_type), 16'(got.asdu_type));
          check_field("asdu_length", 16'(want.asdu_length), 16'(got.asdu_length));
        end
        if (got.kind == KIND_VERDICT) verdict_seen[got.verdict]++;
        else payload_seen++;
      end
      if (rx_if.valid && rx_if.ready) begin
        deframe_byte(rx_if.rx_byte);
        bytes_sent++;
      end
      if (cfg_if.valid && cfg_if.ready) station_q = cfg_if.station_address;

      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no request moved for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, deframed_q.size());
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst                    = 1'b1;
    rx_if.valid            = 1'b0;
    rx_if.rx_byte          = 8'h00;
    res_if.ready           = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.station_address = 16'h0000;
    station_q              = 16'h0000;
    station_sel            = 16'h0000;
    src_idle_pct           = 0;
    sink_stall_pct         = 0;
    bytes_built            = 0;
    bytes_sent             = 0;
    payload_seen           = 0;
    verdict_seen           = '{0, 0, 0, 0};
    errors                 = 0;
    restart_hunt(8'h00);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: station address left at its reset value
    put(8'h00);
    put(8'hFF);
    queue_frame(1'b0, 0, 8'h7F, 16'h0000, FLAW_NONE);
    // empty ASDU, secondary direction and foreign address: direction wins
    queue_frame(1'b1, 0, 8'h30, 16'hFFFF, FLAW_NONE);
    // second L differs and reopens a frame, which then carries a short length
    put(START_VAR);
    put(8'h05);
    put(START_VAR);
    put(8'h02);
    // bad sum on a foreign-address frame: checksum wins
    queue_frame(1'b0, 0, 8'hC0, 16'hFFFF, FLAW_SUM);
    wait_quiet();

    for (int ph = 1; ph <= 4; ph++) begin
      case (ph)
        1: begin
          src_idle_pct = 0;  sink_stall_pct = 0;  station_sel = 16'hFFFF;
        end
        2: begin
          src_idle_pct = 67; sink_stall_pct = 0;  station_sel = 16'($urandom);
        end
        3: begin
          src_idle_pct = 0;  sink_stall_pct = 67; station_sel = 16'h0000;
        end
        default: begin
          src_idle_pct = 24; sink_stall_pct = 24; station_sel = 16'($urandom);
        end
      endcase
      write_station(station_sel);
      if (ph == 1) begin
        queue_frame(1'b1, 252, 8'h40 | 8'($urandom_range(63)), station_sel, FLAW_NONE);
      end
      queue_traffic(PHASE_BYTES);
      wait_quiet();
    end

    $display("Covered %0d line bytes in 5 phases across 4 station addresses and idle patterns,",
             bytes_sent);
    $display("checking %0d ASDU bytes and verdicts ok %0d, checksum %0d,",
             payload_seen, verdict_seen[VERDICT_OK], verdict_seen[VERDICT_CHECKSUM]);
    $display("not primary %0d, address %0d",
             verdict_seen[VERDICT_NOT_PRM], verdict_seen[VERDICT_ADDRESS]);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
